// ----- hw/rtl/ica_pkg.sv -----
// ============================================================================
// ica_pkg
// Types, defaults and state codes shared by the interval admission core.
// ============================================================================
package ica_pkg;

    localparam int unsigned POSITIONS_DEF   = 1024;
    localparam int unsigned BUCKET_SIZE_DEF = 32;
    localparam logic [15:0] CAPACITY_RESET  = 16'd100;

    typedef struct packed {
        logic [9:0]  first_stop;
        logic [10:0] end_stop;
        logic [15:0] demand;
    } req_item_t;

    typedef struct packed {
        logic [15:0] granted;
        logic [15:0] peak_load;
        logic [31:0] total_granted;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SPLIT,
        ST_PEAK,
        ST_GRANT,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/interval_capacity_admission_core.sv -----
// ============================================================================
// interval_capacity_admission_core
// Range admission against a bucketed load row: range max, grant, range add.
// ============================================================================
// One request at a time. A request covering S steps (one step is a single
// position in a partial bucket or one whole bucket; S <= 2*(BUCKET_SIZE-1)
// plus the number of whole buckets) passes ST_IDLE, which clamps the range,
// ST_DIV and ST_SPLIT, which split its start into bucket and offset, ST_PEAK
// with pipelined reads for the peak, ST_GRANT, then ST_ADD_RD and ST_ADD_WR,
// a read-modify-write per step for the add pass (skipped when the grant is
// zero or the range is empty), and ST_DONE, which hands the result to the
// output register once it is free. The add pass is bound by the single read
// and write port of the load and bucket memories. After reset the block
// sweeps both memories to zero, one entry per cycle, before req_ready rises.
// The output register lets the next request start while a result waits.

module interval_capacity_admission_core
    import ica_pkg::*;
#(
    parameter int unsigned POSITIONS   = POSITIONS_DEF,
    parameter int unsigned BUCKET_SIZE = BUCKET_SIZE_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_item_t   req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_item_t   rsp,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    // position values run 0..POSITIONS inclusive
    localparam int unsigned PW   = $clog2(POSITIONS + 1);
    localparam int unsigned EW   = (PW > 11) ? PW : 11;
    localparam int unsigned AW   = $clog2(POSITIONS);
    localparam int unsigned NB   = (POSITIONS + BUCKET_SIZE - 1) / BUCKET_SIZE;
    localparam int unsigned BW   = (NB > 1) ? $clog2(NB) : 1;
    localparam int unsigned SUBW = $clog2(BUCKET_SIZE + 1);
    // floor(2^PW / BUCKET_SIZE): quotient estimate is exact or one low
    localparam logic [PW:0] RECIP = (PW + 1)'((64'd1 << PW) / BUCKET_SIZE);

    // ------------------------------------------------------------------
    // memories: per-position raw load, per-bucket {offset, peak}
    // ------------------------------------------------------------------
    logic [15:0] pt_mem [POSITIONS];
    logic [31:0] bk_mem [NB];

    logic          pt_we, pt_re;
    logic [AW-1:0] pt_waddr, pt_raddr;
    logic [15:0]   pt_wdata, pt_rdata_reg;
    logic          bk_we, bk_re;
    logic [BW-1:0] bk_waddr, bk_raddr;
    logic [31:0]   bk_wdata, bk_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (pt_re)
        begin
            pt_rdata_reg <= pt_mem[pt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bk_we)
        begin
            bk_mem[bk_waddr] <= bk_wdata;
        end
        if (bk_re)
        begin
            bk_rdata_reg <= bk_mem[bk_raddr];
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [15:0]     capacity_reg;
    logic [PW-1:0]   lo_reg, lo_next;
    logic [PW-1:0]   hi_reg, hi_next;
    logic [15:0]     demand_reg, demand_next;
    logic [BW-1:0]   quot_reg, quot_next;
    logic [BW-1:0]   lo_bkt_reg, lo_bkt_next;
    logic [SUBW-1:0] lo_sub_reg, lo_sub_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [BW-1:0]   bkt_reg, bkt_next;
    logic [SUBW-1:0] sub_reg, sub_next;
    logic            rd_vld_reg, rd_vld_next;
    logic            rd_whole_reg, rd_whole_next;
    logic [16:0]     best_reg, best_next;
    logic [15:0]     grant_reg, grant_next;
    logic [31:0]     grant_sum_reg, grant_sum_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_item_t       rsp_reg, rsp_next;

    // ------------------------------------------------------------------
    // shared combinational terms
    // ------------------------------------------------------------------
    logic [EW-1:0]   first_ext, end_ext;
    logic [PW-1:0]   lo_clamp, hi_clamp;
    logic [2*PW:0]   quot_prod;
    logic [PW:0]     quot_base, rem_raw;
    logic            step_whole, issue, range_nonempty;
    logic [PW-1:0]   pos_adv;
    logic [BW-1:0]   bkt_adv;
    logic [SUBW-1:0] sub_adv, sub_inc;
    logic [16:0]     rd_value, cap_ext;
    logic [15:0]     room, grant_calc;
    logic [32:0]     sum_wide;
    logic [15:0]     add_pt;
    logic [16:0]     add_eff;

    assign first_ext = EW'(req.first_stop);
    assign end_ext   = EW'(req.end_stop);
    assign lo_clamp  = (first_ext > EW'(POSITIONS)) ? PW'(POSITIONS) : PW'(first_ext);
    assign hi_clamp  = (end_ext > EW'(POSITIONS)) ? PW'(POSITIONS) : PW'(end_ext);

    assign quot_prod = (2*PW + 1)'(lo_reg) * (2*PW + 1)'(RECIP);
    assign quot_base = (PW + 1)'(quot_reg) * (PW + 1)'(BUCKET_SIZE);
    assign rem_raw   = (PW + 1)'(lo_reg) - quot_base;

    assign range_nonempty = lo_reg < hi_reg;
    assign issue          = pos_reg < hi_reg;
    // whole bucket when aligned to its start and fully inside the range
    assign step_whole = (sub_reg == '0) &&
                        ((PW + 1)'(pos_reg) + (PW + 1)'(BUCKET_SIZE) <= (PW + 1)'(hi_reg));
    assign sub_inc    = sub_reg + 1'b1;

    always_comb
    begin
        if (step_whole)
        begin
            pos_adv = pos_reg + PW'(BUCKET_SIZE);
            bkt_adv = bkt_reg + 1'b1;
            sub_adv = '0;
        end
        else if (sub_inc == SUBW'(BUCKET_SIZE))
        begin
            pos_adv = pos_reg + 1'b1;
            bkt_adv = bkt_reg + 1'b1;
            sub_adv = '0;
        end
        else
        begin
            pos_adv = pos_reg + 1'b1;
            bkt_adv = bkt_reg;
            sub_adv = sub_inc;
        end
    end

    // effective load of the step whose read returned this cycle
    assign rd_value = rd_whole_reg ? {1'b0, bk_rdata_reg[15:0]}
                                   : {1'b0, pt_rdata_reg} + {1'b0, bk_rdata_reg[31:16]};

    assign cap_ext    = {1'b0, capacity_reg};
    assign room       = (best_reg >= cap_ext) ? 16'd0 : 16'(cap_ext - best_reg);
    assign grant_calc = (demand_reg < room) ? demand_reg : room;
    assign sum_wide   = {1'b0, grant_sum_reg} + 33'(grant_calc);

    assign add_pt  = pt_rdata_reg + grant_reg;
    assign add_eff = {1'b0, add_pt} + {1'b0, bk_rdata_reg[31:16]};

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(POSITIONS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:   state_next = ST_SPLIT;
            ST_SPLIT: state_next = ST_PEAK;
            ST_PEAK:
            begin
                if (!issue)
                begin
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                if (grant_calc != '0 && range_nonempty)
                begin
                    state_next = ST_ADD_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR:
            begin
                if (pos_adv < hi_reg)
                begin
                    state_next = ST_ADD_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs: handshake and memory ports
    // ------------------------------------------------------------------
    always_comb
    begin
        req_ready = 1'b0;
        pt_we     = 1'b0;
        pt_waddr  = pos_reg[AW-1:0];
        pt_wdata  = add_pt;
        pt_re     = 1'b0;
        pt_raddr  = pos_reg[AW-1:0];
        bk_we     = 1'b0;
        bk_waddr  = bkt_reg;
        bk_wdata  = bk_rdata_reg;
        bk_re     = 1'b0;
        bk_raddr  = bkt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                pt_we    = 1'b1;
                pt_waddr = clr_cnt_reg;
                pt_wdata = '0;
                bk_we    = (32'(clr_cnt_reg) < NB);
                bk_waddr = clr_cnt_reg[BW-1:0];
                bk_wdata = '0;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_PEAK:
            begin
                pt_re = issue;
                bk_re = issue;
            end
            ST_ADD_RD:
            begin
                pt_re = 1'b1;
                bk_re = 1'b1;
            end
            ST_ADD_WR:
            begin
                bk_we = 1'b1;
                if (step_whole)
                begin
                    // lazy add on the whole bucket
                    bk_wdata = {bk_rdata_reg[31:16] + grant_reg,
                                bk_rdata_reg[15:0] + grant_reg};
                end
                else
                begin
                    pt_we = 1'b1;
                    if (add_eff > {1'b0, bk_rdata_reg[15:0]})
                    begin
                        bk_wdata = {bk_rdata_reg[31:16], add_eff[15:0]};
                    end
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        demand_next    = demand_reg;
        quot_next      = quot_reg;
        lo_bkt_next    = lo_bkt_reg;
        lo_sub_next    = lo_sub_reg;
        pos_next       = pos_reg;
        bkt_next       = bkt_reg;
        sub_next       = sub_reg;
        rd_vld_next    = rd_vld_reg;
        rd_whole_next  = rd_whole_reg;
        best_next      = best_reg;
        grant_next     = grant_reg;
        grant_sum_next = grant_sum_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    lo_next     = lo_clamp;
                    hi_next     = hi_clamp;
                    demand_next = req.demand;
                    best_next   = '0;
                    rd_vld_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                quot_next = quot_prod[PW +: BW];
            end
            ST_SPLIT:
            begin
                // estimate is exact or one low
                if (rem_raw >= (PW + 1)'(BUCKET_SIZE))
                begin
                    lo_bkt_next = quot_reg + 1'b1;
                    lo_sub_next = SUBW'(rem_raw - (PW + 1)'(BUCKET_SIZE));
                end
                else
                begin
                    lo_bkt_next = quot_reg;
                    lo_sub_next = SUBW'(rem_raw);
                end
                pos_next = lo_reg;
                bkt_next = lo_bkt_next;
                sub_next = lo_sub_next;
            end
            ST_PEAK:
            begin
                if (rd_vld_reg && rd_value > best_reg)
                begin
                    best_next = rd_value;
                end
                rd_vld_next   = issue;
                rd_whole_next = step_whole;
                if (issue)
                begin
                    pos_next = pos_adv;
                    bkt_next = bkt_adv;
                    sub_next = sub_adv;
                end
            end
            ST_GRANT:
            begin
                grant_next = grant_calc;
                if (grant_calc != '0)
                begin
                    grant_sum_next = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                end
                pos_next = lo_reg;
                bkt_next = lo_bkt_reg;
                sub_next = lo_sub_reg;
            end
            ST_ADD_WR:
            begin
                pos_next = pos_adv;
                bkt_next = bkt_adv;
                sub_next = sub_adv;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.granted       = grant_reg;
                    rsp_next.peak_load     = best_reg[15:0];
                    rsp_next.total_granted = grant_sum_reg;
                end
            end
            default:
            begin
                rd_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            grant_sum_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            grant_sum_reg <= grant_sum_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // capacity is written straight from the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        demand_reg   <= demand_next;
        quot_reg     <= quot_next;
        lo_bkt_reg   <= lo_bkt_next;
        lo_sub_reg   <= lo_sub_next;
        pos_reg      <= pos_next;
        bkt_reg      <= bkt_next;
        sub_reg      <= sub_next;
        rd_whole_reg <= rd_whole_next;
        best_reg     <= best_next;
        grant_reg    <= grant_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD_WR |-> $past(state_reg) == ST_ADD_RD)
        else $error("add write without its read");

    a_add_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD_WR |-> pos_reg < hi_reg)
        else $error("add step outside range");

    a_peak_data_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PEAK && rd_vld_reg |-> $past(pt_re) && $past(bk_re))
        else $error("peak data used without a read");

    a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.granted != '0 |->
            {1'b0, rsp_reg.peak_load} + {1'b0, rsp_reg.granted} <= {1'b0, capacity_reg})
        else $error("grant exceeds capacity");

    a_sum_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> grant_sum_reg >= $past(grant_sum_reg))
        else $error("running total decreased");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb
// Regression for interval_capacity_admission_core. A bucketed shadow of the
// load row predicts every result, and a monitor checks each response transfer
// against the oldest prediction. Traffic is directed corner cases first, then
// sorted request batches with noise, then full-demand empty ranges with no
// idling that push the running total up by the whole capacity each time.
// ============================================================================
module tb;
    import ica_pkg::*;

    localparam int unsigned ROW = POSITIONS_DEF;
    localparam int unsigned BKT = BUCKET_SIZE_DEF;
    localparam int unsigned NBK = (ROW + BKT - 1) / BKT;

    // ------------------------------------------------------------------------
    // DUT connections. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_item_t   req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_item_t   rsp;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    interval_capacity_admission_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow of the load row: per-position load without the bucket lift, the
    // lazy lift per bucket, the highest effective load per bucket, the total.
    // ------------------------------------------------------------------------
    int unsigned load_row    [ROW];
    int unsigned bucket_lift [NBK];
    int unsigned bucket_top  [NBK];
    int unsigned grant_total = 0;
    int unsigned cap_limit   = int'(CAPACITY_RESET);

    rsp_item_t   expected_rsp [$];

    bit          idle_on       = 1'b1;
    int          fail_count    = 0;
    int          sent_count    = 0;
    int          checked_count = 0;
    int          zero_grants   = 0;
    int          cap_writes    = 0;

    // A whole bucket starts at p and ends at or before hi.
    function automatic bit spans_bucket(int unsigned p, int unsigned hi);
        return (p % BKT) == 0 && p + BKT <= hi;
    endfunction

    // Predict one admission and advance the shadow state.
    function automatic rsp_item_t admit(req_item_t r);
        int unsigned lo;
        int unsigned hi;
        int unsigned p;
        int unsigned b;
        int unsigned v;
        int unsigned top;
        int unsigned room;
        int unsigned g;
        int unsigned eff;
        rsp_item_t   o;
        lo  = int'(r.first_stop) > ROW ? ROW : int'(r.first_stop);
        hi  = int'(r.end_stop) > ROW ? ROW : int'(r.end_stop);
        top = 0;
        // Peak: single positions in partial buckets, stored peak for whole ones
        p = lo;
        while (p < hi)
        begin
            b = p / BKT;
            if (spans_bucket(p, hi))
            begin
                v = bucket_top[b];
                p += BKT;
            end
            else
            begin
                v = load_row[p] + bucket_lift[b];
                p++;
            end
            if (v > top)
                top = v;
        end
        room = (top >= cap_limit) ? 0 : cap_limit - top;
        g    = (int'(r.demand) < room) ? int'(r.demand) : room;
        if (g != 0)
        begin
            p = lo;
            while (p < hi)
            begin
                b = p / BKT;
                if (spans_bucket(p, hi))
                begin
                    bucket_lift[b] = (bucket_lift[b] + g) & 32'h0000_FFFF;
                    bucket_top[b]  = (bucket_top[b] + g) & 32'h0000_FFFF;
                    p += BKT;
                end
                else
                begin
                    load_row[p] = (load_row[p] + g) & 32'h0000_FFFF;
                    eff = load_row[p] + bucket_lift[b];
                    if (eff > bucket_top[b])
                        bucket_top[b] = eff & 32'h0000_FFFF;
                    p++;
                end
            end
            // total sticks at all ones
            if (grant_total > 32'hFFFF_FFFF - g)
                grant_total = 32'hFFFF_FFFF;
            else
                grant_total += g;
        end
        else
            zero_grants++;
        o.granted       = g[15:0];
        o.peak_load     = top[15:0];
        o.total_granted = grant_total;
        return o;
    endfunction

    function automatic int unsigned draw_demand();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return $urandom_range(0, 65535);
        else if (pick < 5)
            return $urandom_range(0, 4095);
        return $urandom_range(0, 255);
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Valid stays high across back-to-back transfers; it only drops
    // for an idle burst or in settle, so it never gets two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_req(input int unsigned f, input int unsigned e, input int unsigned d);
        req_item_t item;
        item.first_stop = 10'(f);
        item.end_stop   = 11'(e);
        item.demand     = 16'(d);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsp.push_back(admit(item));
        sent_count++;
    endtask

    // Drop valid and wait until every predicted result has been transferred.
    // Each request yields exactly one result, so the core is idle after that.
    task automatic settle();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // One-cycle write of the capacity register; only called after settle.
    task automatic write_cap(input int unsigned v);
        cfg_wdata <= 16'(v);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_limit = v & 32'h0000_FFFF;
        cap_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall bursts while idling is on.
    // ------------------------------------------------------------------------
    initial
    begin : rsp_stall
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 7);
            rsp_ready <= (stall_left == 0);
        end
    end

    // Monitor: every response transfer is matched against the oldest prediction.
    initial
    begin : rsp_check
        rsp_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t unexpected result: granted %0d peak %0d total %0d",
                                 $realtime, rsp.granted, rsp.peak_load, rsp.total_granted);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    checked_count++;
                    if (rsp.granted !== want.granted || rsp.peak_load !== want.peak_load ||
                        rsp.total_granted !== want.total_granted)
                    begin
                        fail_count++;
                        // granted / peak / total
                        if (fail_count <= 10)
                            $display("%0t mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $realtime, want.granted, want.peak_load,
                                     want.total_granted, rsp.granted, rsp.peak_load,
                                     rsp.total_granted);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Capacity still at its reset value: fill the row, hit the ceiling, empty
    // and reversed ranges, a range running past the row, zero demand.
    task automatic test_reset_capacity();
        send_req(0, 1024, 40);
        send_req(0, 1024, 65535);
        send_req(0, 1024, 5);
        send_req(500, 500, 65535);
        send_req(1023, 0, 7);
        send_req(1000, 2047, 0);
        send_req(1000, 2047, 30);
    endtask

    // Widest capacity: partial buckets on both ends, a bucket seam, one whole
    // bucket, the largest grant on an empty range, the last position.
    task automatic test_wide_capacity();
        settle();
        write_cap(16'hFFFF);
        send_req(1, 1023, 1000);
        send_req(31, 33, 200);
        send_req(32, 64, 500);
        send_req(0, 0, 65535);
        send_req(1023, 1024, 0);
        send_req(1023, 1024, 1);
    endtask

    // Capacity 1, far below the loads: nothing fits except an empty range.
    task automatic test_lowered_capacity();
        settle();
        write_cap(1);
        send_req(5, 6, 3);
        send_req(700, 300, 65535);
        send_req(0, 1024, 65535);
    endtask

    // Sorted batches (end ascending, start descending, demand descending) with
    // about a fifth noise. Capacity is set just above the current highest load
    // so grants keep landing, or at or below it when lower is set.
    task automatic test_sorted_traffic(input int n, input bit lower);
        int unsigned peak_now;
        int unsigned eff;
        int unsigned new_cap;
        int unsigned cur_end;
        int unsigned span;
        int unsigned step;
        int unsigned f;
        int unsigned d;
        int unsigned prev_first;
        int unsigned prev_demand;
        bit          have_prev;
        settle();
        peak_now = 0;
        for (int p = 0; p < ROW; p++)
        begin
            eff = load_row[p] + bucket_lift[p / BKT];
            if (eff > peak_now)
                peak_now = eff;
        end
        if (lower)
            new_cap = (peak_now > 1) ? $urandom_range(1, peak_now) : 1;
        else
        begin
            new_cap = peak_now + $urandom_range(20, 4000);
            if (new_cap > 65535)
                new_cap = 65535;
        end
        write_cap(new_cap);
        cur_end     = $urandom_range(1, 64);
        prev_first  = 0;
        prev_demand = 0;
        have_prev   = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_req($urandom_range(0, 1023), $urandom_range(0, 2047), $urandom_range(0, 65535));
            else
            begin
                if (!have_prev || $urandom_range(0, 2) != 0)
                begin
                    // next end; wrap into a fresh batch past the row
                    cur_end += $urandom_range(1, 96);
                    if (cur_end > ROW)
                        cur_end = $urandom_range(1, 64);
                    span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROW)
                                                         : $urandom_range(0, 70);
                    f = (span >= cur_end) ? 0 : cur_end - span;
                    if (f > ROW - 1)
                        f = ROW - 1;
                    d = draw_demand();
                end
                else
                begin
                    // same end: start moves down, demand drops on a tie
                    step = $urandom_range(0, prev_first < 40 ? prev_first : 40);
                    f    = prev_first - step;
                    d    = (step == 0) ? $urandom_range(0, prev_demand) : draw_demand();
                end
                prev_first  = f;
                prev_demand = d;
                have_prev   = 1'b1;
                send_req(f, cur_end, d);
            end
        end
    endtask

    // No idling from here on. Empty ranges at full demand push the total up
    // by the whole capacity on every transfer, back to back.
    task automatic test_full_demand_empty(input int n);
        int unsigned f;
        idle_on = 1'b0;
        settle();
        write_cap(16'hFFFF);
        for (int i = 0; i < n; i++)
        begin
            f = $urandom_range(0, 1023);
            send_req(f, $urandom_range(0, f), 65535);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_capacity();
        test_wide_capacity();
        test_lowered_capacity();
        test_sorted_traffic(300, 1'b0);
        test_sorted_traffic(150, 1'b1);
        test_sorted_traffic(300, 1'b0);
        test_full_demand_empty(150);

        // drain, then allow one worst-case request time for stray results
        settle();
        repeat (300) @(posedge clk);

        $display("covered %0d requests, %0d results checked, %0d zero grants, %0d capacity writes",
                 sent_count, checked_count, zero_grants, cap_writes);
        $display("sorted batches with noise, empty and clamped ranges, final total %0d",
                 grant_total);
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("interval_capacity_admission_core regression: pass");
        else
            $display("interval_capacity_admission_core regression: fail");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #50_000_000;
        $display("timeout with %0d results outstanding", expected_rsp.size());
        $display("interval_capacity_admission_core regression: fail");
        $finish;
    end

endmodule
